>>> sv/wsl_pkg.sv
// Shared types and constants for the wheel speed limiter.
// Used by wsl_front, wsl_fifo, wsl_back and wheel_speed_limiter; no dependencies.

package wsl_pkg;

    localparam int NUM_WHEELS   = 4;
    localparam int WHEEL_IDX_W  = $clog2(NUM_WHEELS);
    localparam int SPEED_W      = 16;
    localparam int MAG_W        = SPEED_W + 1;
    localparam int LIMIT_W      = 15;
    localparam int PROD_W       = MAG_W + LIMIT_W;
    localparam int QUO_W        = 16;
    localparam int DIV_STEPS    = QUO_W / 2;
    localparam int STEP_W       = $clog2(DIV_STEPS);
    localparam int TICK_W       = 20;
    localparam int TICK_WRAP    = 1000000;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20000);

    localparam logic [1:0] PAIR_NONE   = 2'd0;
    localparam logic [1:0] PAIR_FIRST  = 2'd1;
    localparam logic [1:0] PAIR_SECOND = 2'd2;

    // One classified tick, handed from the front end to the divider back end.
    typedef struct packed {
        logic                                fault;
        logic                                scale;
        logic [1:0]                          pair;
        logic [LIMIT_W-1:0]                  limit;
        logic [MAG_W-1:0]                    max_mag;
        logic [NUM_WHEELS-1:0][MAG_W-1:0]    mag;
        logic [NUM_WHEELS-1:0][SPEED_W-1:0]  speed;
    } wsl_job_t;

endpackage

>>> sv/wheel_speed_limiter.sv
// Top level of the wheel speed limiter: front end, job queue and divider back end.
// Depends on wsl_pkg, wsl_front, wsl_fifo and wsl_back.
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_wheel_speed_0..3, s_link_fault
//   m_        out        m_valid / m_ready   m_target_0..3, m_send_pair, m_was_scaled
//   cfg_      in         cfg_wr_en           cfg_wr_data (speed limit)
//
// A tick that needs scaling passes through the back end as a pop, then per wheel one
// multiply and the divider steps, then loading the output beat. Fault ticks and ticks
// within the limit go straight to the output beat. The shared divider sets the rate.
// The two-entry queue lets the front end take beats while the back end is busy.
// Reset is synchronous, active low; it clears the tick counter and restores the limit.

module wheel_speed_limiter import wsl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [LIMIT_W-1:0]  cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SPEED_W-1:0]  s_wheel_speed_0,
    input  logic [SPEED_W-1:0]  s_wheel_speed_1,
    input  logic [SPEED_W-1:0]  s_wheel_speed_2,
    input  logic [SPEED_W-1:0]  s_wheel_speed_3,
    input  logic                s_link_fault,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SPEED_W-1:0]  m_target_0,
    output logic [SPEED_W-1:0]  m_target_1,
    output logic [SPEED_W-1:0]  m_target_2,
    output logic [SPEED_W-1:0]  m_target_3,
    output logic [1:0]          m_send_pair,
    output logic                m_was_scaled
);

    logic      q_full;
    logic      q_empty;
    logic      q_push;
    logic      q_pop;
    wsl_job_t  push_job;
    wsl_job_t  pop_job;

    wsl_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_wheel_speed_0 (s_wheel_speed_0),
        .s_wheel_speed_1 (s_wheel_speed_1),
        .s_wheel_speed_2 (s_wheel_speed_2),
        .s_wheel_speed_3 (s_wheel_speed_3),
        .s_link_fault    (s_link_fault),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_job           (push_job)
    );

    wsl_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_job),
        .empty     (q_empty)
    );

    wsl_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_job        (pop_job),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_target_0   (m_target_0),
        .m_target_1   (m_target_1),
        .m_target_2   (m_target_2),
        .m_target_3   (m_target_3),
        .m_send_pair  (m_send_pair),
        .m_was_scaled (m_was_scaled)
    );

endmodule

>>> sv/wsl_front.sv
// Front end: takes input beats, keeps the tick counter and the speed limit,
// finds the largest magnitude and classifies each tick. Depends on wsl_pkg.

module wsl_front import wsl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [LIMIT_W-1:0]  cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SPEED_W-1:0]  s_wheel_speed_0,
    input  logic [SPEED_W-1:0]  s_wheel_speed_1,
    input  logic [SPEED_W-1:0]  s_wheel_speed_2,
    input  logic [SPEED_W-1:0]  s_wheel_speed_3,
    input  logic                s_link_fault,
    input  logic                q_full,
    output logic                q_push,
    output wsl_job_t            q_job
);

    logic [LIMIT_W-1:0] speed_limit_reg;
    logic [LIMIT_W-1:0] speed_limit_next;
    logic [TICK_W-1:0]  tick_count_reg;
    logic [TICK_W-1:0]  tick_count_next;
    logic [TICK_W-1:0]  tick_inc;
    logic [MAG_W-1:0]   max01;
    logic [MAG_W-1:0]   max23;
    logic [MAG_W-1:0]   max_all;
    logic [NUM_WHEELS-1:0][SPEED_W-1:0] speed;
    logic [NUM_WHEELS-1:0][MAG_W-1:0]   mag;

    function automatic logic [MAG_W-1:0] magnitude(input logic [SPEED_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = {1'b0, v};
        if (v[SPEED_W-1]) begin
            return (MAG_W'(1) << SPEED_W) - ext;
        end
        return ext;
    endfunction

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    assign speed[0] = s_wheel_speed_0;
    assign speed[1] = s_wheel_speed_1;
    assign speed[2] = s_wheel_speed_2;
    assign speed[3] = s_wheel_speed_3;

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            mag[i] = magnitude(speed[i]);
        end
    end

    assign max01   = (mag[0] > mag[1]) ? mag[0] : mag[1];
    assign max23   = (mag[2] > mag[3]) ? mag[2] : mag[3];
    assign max_all = (max01 > max23) ? max01 : max23;

    // Parity comes from the incremented count, before the wrap.
    assign tick_inc = tick_count_reg + TICK_W'(1);

    always_comb begin
        tick_count_next = tick_count_reg;
        if (q_push) begin
            tick_count_next = (tick_inc > TICK_W'(TICK_WRAP)) ? '0 : tick_inc;
        end
        speed_limit_next = cfg_wr_en ? cfg_wr_data : speed_limit_reg;
    end

    always_comb begin
        q_job.fault   = s_link_fault;
        q_job.scale   = !s_link_fault && (max_all > {{(MAG_W-LIMIT_W){1'b0}}, speed_limit_reg});
        q_job.pair    = s_link_fault ? PAIR_NONE : (tick_inc[0] ? PAIR_SECOND : PAIR_FIRST);
        q_job.limit   = speed_limit_reg;
        q_job.max_mag = max_all;
        q_job.mag     = mag;
        q_job.speed   = speed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg  <= '0;
            speed_limit_reg <= LIMIT_RESET;
        end else begin
            tick_count_reg  <= tick_count_next;
            speed_limit_reg <= speed_limit_next;
        end
    end

    a_tick_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_count_reg <= TICK_W'(TICK_WRAP))
        else $error("tick counter went past the wrap value");

endmodule

>>> sv/wsl_fifo.sv
// Two-entry job queue between the front end and the divider back end.
// Depends on wsl_pkg for the job type and depth.

module wsl_fifo import wsl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  wsl_job_t  push_data,
    output logic      full,
    input  logic      pop,
    output wsl_job_t  pop_data,
    output logic      empty
);

    wsl_job_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointers wrap naturally because the depth is a power of two.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count exceeds its depth");

endmodule

>>> sv/wsl_back.sv
// Back end: scales over-limit ticks by limit / max with one multiplier and a shared
// two-bit-per-cycle restoring divider, then holds the result beat. Depends on wsl_pkg.

module wsl_back import wsl_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  wsl_job_t            q_job,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SPEED_W-1:0]  m_target_0,
    output logic [SPEED_W-1:0]  m_target_1,
    output logic [SPEED_W-1:0]  m_target_2,
    output logic [SPEED_W-1:0]  m_target_3,
    output logic [1:0]          m_send_pair,
    output logic                m_was_scaled
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;

    logic [2:0]               st_reg, st_next;
    wsl_job_t                 job_reg, job_next;
    logic [WHEEL_IDX_W-1:0]   idx_reg, idx_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [MAG_W-1:0]         rem_reg, rem_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic [NUM_WHEELS-1:0][SPEED_W-1:0] res_reg, res_next;

    logic                     m_valid_reg, m_valid_next;
    logic [NUM_WHEELS-1:0][SPEED_W-1:0] m_target_reg, m_target_next;
    logic [1:0]               m_send_pair_reg, m_send_pair_next;
    logic                     m_was_scaled_reg, m_was_scaled_next;

    logic [PROD_W-1:0]        prod;
    logic [MAG_W:0]           trial1, trial2, divisor;
    logic                     ge1, ge2;
    logic [MAG_W-1:0]         rem1, rem2;
    logic [QUO_W-1:0]         quo_step;
    logic [SPEED_W-1:0]       q_signed;
    logic                     out_free;

    assign out_free = !m_valid_reg || m_ready;

    // One multiply per wheel, registered before the divider starts.
    assign prod = job_reg.mag[idx_reg] * {{(MAG_W-LIMIT_W){1'b0}}, job_reg.limit};

    // Two restoring steps per cycle; the remainder always stays below max_mag.
    assign divisor  = {1'b0, job_reg.max_mag};
    assign trial1   = {rem_reg, quo_reg[QUO_W-1]};
    assign ge1      = trial1 >= divisor;
    assign rem1     = ge1 ? MAG_W'(trial1 - divisor) : MAG_W'(trial1);
    assign trial2   = {rem1, quo_reg[QUO_W-2]};
    assign ge2      = trial2 >= divisor;
    assign rem2     = ge2 ? MAG_W'(trial2 - divisor) : MAG_W'(trial2);
    assign quo_step = {quo_reg[QUO_W-3:0], ge1, ge2};
    assign q_signed = job_reg.speed[idx_reg][SPEED_W-1] ? SPEED_W'(~quo_step + QUO_W'(1))
                                                       : SPEED_W'(quo_step);

    always_comb begin
        st_next           = st_reg;
        job_next          = job_reg;
        idx_next          = idx_reg;
        step_next         = step_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        res_next          = res_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_target_next     = m_target_reg;
        m_send_pair_next  = m_send_pair_reg;
        m_was_scaled_next = m_was_scaled_reg;
        q_pop             = 1'b0;

        case (st_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    job_next = q_job;
                    idx_next = '0;
                    if (q_job.fault) begin
                        res_next = '0;
                        st_next  = ST_OUT;
                    end else if (!q_job.scale) begin
                        res_next = q_job.speed;
                        st_next  = ST_OUT;
                    end else begin
                        st_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                rem_next  = MAG_W'(prod[PROD_W-1:QUO_W]);
                quo_next  = prod[QUO_W-1:0];
                step_next = '0;
                st_next   = ST_DIV;
            end
            ST_DIV: begin
                rem_next  = rem2;
                quo_next  = quo_step;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    res_next[idx_reg] = q_signed;
                    if (idx_reg == WHEEL_IDX_W'(NUM_WHEELS - 1)) begin
                        st_next = ST_OUT;
                    end else begin
                        idx_next = idx_reg + WHEEL_IDX_W'(1);
                        st_next  = ST_MUL;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_target_next     = res_reg;
                    m_send_pair_next  = job_reg.pair;
                    m_was_scaled_next = job_reg.scale;
                    st_next           = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        job_reg          <= job_next;
        idx_reg          <= idx_next;
        step_reg         <= step_next;
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        res_reg          <= res_next;
        m_target_reg     <= m_target_next;
        m_send_pair_reg  <= m_send_pair_next;
        m_was_scaled_reg <= m_was_scaled_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_target_0   = m_target_reg[0];
    assign m_target_1   = m_target_reg[1];
    assign m_target_2   = m_target_reg[2];
    assign m_target_3   = m_target_reg[3];
    assign m_send_pair  = m_send_pair_reg;
    assign m_was_scaled = m_was_scaled_reg;

    a_no_zero_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_DIV) |-> (job_reg.max_mag != '0))
        else $error("divider running with a zero divisor");

    a_quotient_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_DIV && step_reg == STEP_W'(DIV_STEPS - 1))
            |-> (quo_step <= QUO_W'(job_reg.limit)))
        else $error("scaled magnitude exceeds the speed limit");

    a_fault_beat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_send_pair_reg == PAIR_NONE)
            |-> (m_target_reg == '0 && !m_was_scaled_reg))
        else $error("fault beat carries nonzero targets");

endmodule

>>> test/tb_wheel_speed_limiter.sv
// Self-checking testbench for wheel_speed_limiter: directed and random control ticks,
// checked beat by beat against a scoreboard that predicts the limited targets.
// Depends on wsl_pkg and the wheel_speed_limiter RTL.
`timescale 1ns / 1ps

module tb_wheel_speed_limiter import wsl_pkg::*; ();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 116;

    typedef logic [NUM_WHEELS-1:0][SPEED_W-1:0] speed_set_t;

    typedef struct packed {
        speed_set_t  target;
        logic [1:0]  pair;
        logic        scaled;
    } tick_result_t;

    class wheel_scoreboard;
        logic [LIMIT_W-1:0] limit;
        logic [TICK_W-1:0]  tick;
        tick_result_t       due_q[$];
        int errors;
        int ticks;
        int checked;
        int scaled;
        int faults;

        function new();
            limit   = LIMIT_RESET;
            tick    = '0;
            errors  = 0;
            ticks   = 0;
            checked = 0;
            scaled  = 0;
            faults  = 0;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // Works out the beat that one accepted tick must produce and queues it.
        function void note_tick(speed_set_t sp, logic fault);
            tick_result_t       r;
            logic [MAG_W-1:0]   mag [NUM_WHEELS];
            logic [MAG_W-1:0]   peak;
            logic [PROD_W-1:0]  q;
            r    = '0;
            peak = '0;
            ticks++;
            // Parity comes from the incremented count, before the wrap.
            tick   = tick + 1'b1;
            r.pair = tick[0] ? PAIR_SECOND : PAIR_FIRST;
            if (tick > TICK_W'(TICK_WRAP)) tick = '0;
            if (fault) begin
                faults++;
                r.pair = PAIR_NONE;
                due_q.push_back(r);
                return;
            end
            for (int i = 0; i < NUM_WHEELS; i++) begin
                mag[i] = sp[i][SPEED_W-1] ? MAG_W'(17'h10000) - {1'b0, sp[i]} : {1'b0, sp[i]};
                if (mag[i] > peak) peak = mag[i];
            end
            r.scaled = peak > MAG_W'(limit);
            if (r.scaled) scaled++;
            for (int i = 0; i < NUM_WHEELS; i++) begin
                q = PROD_W'(mag[i]);
                if (r.scaled) q = (PROD_W'(mag[i]) * PROD_W'(limit)) / PROD_W'(peak);
                r.target[i] = sp[i][SPEED_W-1] ? ~q[SPEED_W-1:0] + 1'b1 : q[SPEED_W-1:0];
            end
            due_q.push_back(r);
        endfunction

        function void check_result(tick_result_t got);
            tick_result_t want;
            bit           bad;
            checked++;
            if (due_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("beat %0d arrived with nothing outstanding", checked);
                return;
            end
            want = due_q.pop_front();
            bad  = (got.pair !== want.pair) || (got.scaled !== want.scaled);
            for (int i = 0; i < NUM_WHEELS; i++) bad |= (got.target[i] !== want.target[i]);
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("beat %0d: got targets %0d %0d %0d %0d pair %0d scaled %0d",
                             checked, $signed(got.target[0]), $signed(got.target[1]),
                             $signed(got.target[2]), $signed(got.target[3]),
                             got.pair, got.scaled);
                    $display("      wanted targets %0d %0d %0d %0d pair %0d scaled %0d",
                             $signed(want.target[0]), $signed(want.target[1]),
                             $signed(want.target[2]), $signed(want.target[3]),
                             want.pair, want.scaled);
                end
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn         = 1'b0;
    logic                cfg_wr_en       = 1'b0;
    logic [LIMIT_W-1:0]  cfg_wr_data     = '0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [SPEED_W-1:0]  s_wheel_speed_0 = '0;
    logic [SPEED_W-1:0]  s_wheel_speed_1 = '0;
    logic [SPEED_W-1:0]  s_wheel_speed_2 = '0;
    logic [SPEED_W-1:0]  s_wheel_speed_3 = '0;
    logic                s_link_fault    = 1'b0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [SPEED_W-1:0]  m_target_0;
    logic [SPEED_W-1:0]  m_target_1;
    logic [SPEED_W-1:0]  m_target_2;
    logic [SPEED_W-1:0]  m_target_3;
    logic [1:0]          m_send_pair;
    logic                m_was_scaled;

    int              src_idle   = 0;
    int              sink_stall = 0;
    int              cycles     = 0;
    wheel_scoreboard sb;

    wheel_speed_limiter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_wheel_speed_0 (s_wheel_speed_0),
        .s_wheel_speed_1 (s_wheel_speed_1),
        .s_wheel_speed_2 (s_wheel_speed_2),
        .s_wheel_speed_3 (s_wheel_speed_3),
        .s_link_fault    (s_link_fault),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_target_0      (m_target_0),
        .m_target_1      (m_target_1),
        .m_target_2      (m_target_2),
        .m_target_3      (m_target_3),
        .m_send_pair     (m_send_pair),
        .m_was_scaled    (m_was_scaled)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d beats outstanding",
                     cycles, sb.pending());
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: check each accepted beat, then pick ready for the next edge.
    initial begin
        tick_result_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.target[0] = m_target_0;
                got.target[1] = m_target_1;
                got.target[2] = m_target_2;
                got.target[3] = m_target_3;
                got.pair      = m_send_pair;
                got.scaled    = m_was_scaled;
                sb.check_result(got);
            end
            m_ready <= ($urandom_range(1, 100) > sink_stall);
        end
    end

    // Called at a clock edge; returns at the edge where the beat is taken.
    // Valid is only lowered when an idle cycle is chosen, so it never toggles in one step.
    task automatic send_tick(logic [SPEED_W-1:0] w0, logic [SPEED_W-1:0] w1,
                             logic [SPEED_W-1:0] w2, logic [SPEED_W-1:0] w3, logic fault);
        speed_set_t sp;
        sp[0] = w0;
        sp[1] = w1;
        sp[2] = w2;
        sp[3] = w3;
        while ($urandom_range(1, 100) <= src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_wheel_speed_0 <= w0;
        s_wheel_speed_1 <= w1;
        s_wheel_speed_2 <= w2;
        s_wheel_speed_3 <= w3;
        s_link_fault    <= fault;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(sp, fault);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // The limit is only changed once every outstanding beat has come back.
    task automatic set_speed_limit(int value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LIMIT_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.limit = LIMIT_W'(value);
    endtask

    function automatic logic [SPEED_W-1:0] rand_speed(int lim);
        int m;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return SPEED_W'($urandom);
            4, 5:       m = $urandom_range(0, lim);
            6:          m = lim;
            7:          m = lim + 1;
            8:          m = $urandom_range(0, 1) ? 32768 : 32767;
            default:    m = $urandom_range(0, 15);
        endcase
        return $urandom_range(0, 1) ? SPEED_W'(-m) : SPEED_W'(m);
    endfunction

    initial begin
        logic [SPEED_W-1:0] w [NUM_WHEELS];
        int                 lim;
        logic               fault;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Limit at its reset value of 20000.
        send_tick(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_tick(16'h7FFF, 16'h8000, 16'd0, 16'd1, 1'b0);
        send_tick(16'd20000, -16'd20000, 16'd5, -16'd5, 1'b0);
        send_tick(16'd20001, -16'd3, 16'd7, 16'd0, 1'b0);
        send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_tick(16'd100, 16'd200, -16'd300, 16'd400, 1'b1);
        send_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_tick(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_tick(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_tick(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);

        // A zero limit clears every nonzero speed, but all-zero speeds are left alone.
        set_speed_limit(0);
        send_tick(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_tick(16'd1, 16'd0, 16'd0, 16'd0, 1'b0);
        send_tick(16'h8000, 16'h7FFF, 16'hFFFF, 16'd1, 1'b0);
        send_tick(16'h8000, 16'h7FFF, 16'hFFFF, 16'd1, 1'b1);

        // At the top limit only the most negative speed forces scaling.
        set_speed_limit(32767);
        send_tick(16'h7FFF, -16'd32767, 16'd1, 16'hFFFF, 1'b0);
        send_tick(16'h8000, 16'h7FFF, -16'd16384, 16'd3, 1'b0);
        send_tick(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);

        set_speed_limit(1);
        send_tick(16'd1, 16'hFFFF, 16'd0, 16'd1, 1'b0);
        send_tick(16'd2, 16'hFFFF, 16'd1, 16'd0, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1:       set_speed_limit(0);
                2:       set_speed_limit(32767);
                3:       set_speed_limit($urandom_range(1, 200));
                4:       set_speed_limit(1);
                6:       set_speed_limit(int'(LIMIT_RESET));
                default: set_speed_limit($urandom_range(0, 32767));
            endcase
            case (p % 4)
                0:       begin src_idle = 0;  sink_stall = 0;  end
                1:       begin src_idle = 79; sink_stall = 0;  end
                2:       begin src_idle = 0;  sink_stall = 79; end
                default: begin src_idle = 38; sink_stall = 38; end
            endcase
            lim = int'(sb.limit);
            repeat (PHASE_TICKS) begin
                fault = ($urandom_range(0, 9) == 0);
                // Some ticks keep every wheel within the limit so unscaled beats show up.
                if ($urandom_range(0, 9) < 3) begin
                    for (int i = 0; i < NUM_WHEELS; i++) begin
                        w[i] = SPEED_W'($urandom_range(0, lim));
                        if ($urandom_range(0, 1)) w[i] = ~w[i] + 1'b1;
                    end
                end else begin
                    for (int i = 0; i < NUM_WHEELS; i++) w[i] = rand_speed(lim);
                end
                send_tick(w[0], w[1], w[2], w[3], fault);
            end
        end

        drain();
        repeat (40) @(posedge aclk);
        $display("%0d ticks sent over %0d limit settings, %0d beats checked",
                 sb.ticks, PHASES + 3, sb.checked);
        $display("%0d faulted, %0d scaled, %0d mismatches", sb.faults, sb.scaled, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
